### design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer modules.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int KIND_W    = 2;
  localparam int SYM_W     = 8;
  localparam int WORD_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  localparam int ACC_W     = PEND_W + WORD_W;   // pending bits plus one code word
  localparam int ALIGN_W   = ACC_W + 1;         // byte multiple for left alignment
  localparam int OBUF_BYTES = 4;
  localparam int OBUF_W    = OBUF_BYTES * BYTE_W;
  localparam int OCNT_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  // Stage-1 item handed to the packer
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } lookup_t;

endpackage

### design/hcbp_if.sv
// ----------------------------------------------------------------------------
// hcbp_if
// Input and output channel interfaces of the Huffman code bit packer.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [hcbp_pkg::KIND_W-1:0]   kind;
  logic [hcbp_pkg::SYM_W-1:0]    symbol;
  logic [hcbp_pkg::WORD_W-1:0]   code_word;
  logic [hcbp_pkg::LEN_W-1:0]    code_length;

  modport source (output valid, kind, symbol, code_word, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [hcbp_pkg::BYTE_W-1:0]   out_byte;
  logic                          last_of_run;
  logic                          stream_end;

  modport source (output valid, out_byte, last_of_run, stream_end, input ready);
  modport sink   (input valid, out_byte, last_of_run, stream_end, output ready);
endinterface

### design/huffman_code_bit_packer_unit.sv
// An input beat is registered in the code table's input register and then
// in the packer's byte output register. Throughput: one item per cycle while
// each item yields at most one byte and the output is ready; an encode with
// n bytes (n up to 4) holds the output register until its last byte is taken.
// Reset: async active low; clears pending bits, pipeline valids and the
// per-entry valid flags of the code table at once (no clearing sweep).
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Table-driven Huffman encoder packing code bits into bytes, MSB first.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbp_in_if.sink     in_i,
  hcbp_out_if.source  out_o
);
  import hcbp_pkg::*;

  lookup_t look;
  logic    take;

  hcbp_code_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .look_o (look)
  );

  hcbp_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .look_i (look),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

### design/hcbp_code_table.sv
// ----------------------------------------------------------------------------
// hcbp_code_table
// Input register and code table: loads write an entry, encodes read one.
// ----------------------------------------------------------------------------
module hcbp_code_table #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbp_in_if.sink           in_i,
  input  logic              take_i,
  output hcbp_pkg::lookup_t look_o
);
  import hcbp_pkg::*;

  localparam int AddrW   = $clog2(SYMBOL_COUNT);
  localparam int SymCmpW = SYM_W + 1;
  localparam int LenLim  = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;

  logic [WORD_W+LEN_W-1:0] code_mem_q [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] ent_vld_q;

  logic                    accept;
  logic                    in_range;
  logic [AddrW-1:0]        addr;
  logic                    wr_en;
  logic [LEN_W-1:0]        len_sat;
  logic [WORD_W-1:0]       word_mask;

  logic                    s1_valid_q, s1_valid_d;
  kind_e                   kind_q;
  logic                    hit_q;
  logic [WORD_W+LEN_W-1:0] rd_q;

  assign in_i.ready = !s1_valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = {1'b0, in_i.symbol} < SymCmpW'(SYMBOL_COUNT);
  assign addr       = in_i.symbol[AddrW-1:0];
  assign wr_en      = accept && in_range && (kind_e'(in_i.kind) == KIND_LOAD);

  always_comb begin
    len_sat = (in_i.code_length > LEN_W'(LenLim)) ? LEN_W'(LenLim) : in_i.code_length;
    if (len_sat == '0) begin
      word_mask = '0;
    end else begin
      word_mask = {WORD_W{1'b1}} >> (LEN_W'(WORD_W) - len_sat);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (take_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ent_vld_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (wr_en) begin
        ent_vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      code_mem_q[addr] <= {in_i.code_word & word_mask, len_sat};
    end
    if (accept) begin
      rd_q   <= code_mem_q[addr];
      hit_q  <= in_range && ent_vld_q[addr];
      kind_q <= kind_e'(in_i.kind);
    end
  end

  // an entry never loaded reads as length zero
  always_comb begin
    look_o.valid = s1_valid_q;
    look_o.kind  = kind_q;
    look_o.word  = rd_q[WORD_W+LEN_W-1:LEN_W];
    look_o.len   = hit_q ? rd_q[LEN_W-1:0] : '0;
  end

endmodule

### design/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and byte output register; drains up to four bytes per item.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcbp_pkg::lookup_t look_i,
  output logic              take_o,
  hcbp_out_if.source        out_o
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [OCNT_W-1:0]  ocnt_q, ocnt_d;
  logic [OBUF_W-1:0]  obuf_q, obuf_d;
  logic               end_q, end_d;

  logic               xfer;
  logic               out_beat;
  logic [ACC_W-1:0]   acc;
  logic [LEN_W-1:0]   total;
  logic [ALIGN_W-1:0] aligned;
  logic [CNT_W-1:0]   rem;
  logic [PEND_W-1:0]  rem_mask;
  logic [BYTE_W-1:0]  flush_byte;

  assign out_beat = out_o.valid && out_o.ready;
  assign take_o   = (ocnt_q == '0) || ((ocnt_q == OCNT_W'(1)) && out_o.ready);
  assign xfer     = look_i.valid && take_o;

  always_comb begin
    acc        = (ACC_W'(pend_q) << look_i.len) | ACC_W'(look_i.word);
    total      = LEN_W'(cnt_q) + look_i.len;
    // earliest stream bit moves to the top
    aligned    = ALIGN_W'(acc) << (LEN_W'(ALIGN_W) - total);
    rem        = total[CNT_W-1:0];
    rem_mask   = {PEND_W{1'b1}} >> (CNT_W'(PEND_W) - rem);
    flush_byte = BYTE_W'({1'b0, pend_q} << (4'(BYTE_W) - {1'b0, cnt_q}));
  end

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    ocnt_d = ocnt_q;
    obuf_d = obuf_q;
    end_d  = end_q;
    if (xfer) begin
      ocnt_d = '0;
      case (look_i.kind)
        KIND_ENCODE: begin
          if (look_i.len != '0) begin
            obuf_d = aligned[ALIGN_W-1:ALIGN_W-OBUF_W];
            ocnt_d = OCNT_W'(total[LEN_W-1:CNT_W]);
            end_d  = 1'b0;
            pend_d = acc[PEND_W-1:0] & rem_mask;
            cnt_d  = rem;
          end
        end
        KIND_FLUSH: begin
          if (cnt_q != '0) begin
            obuf_d = {flush_byte, {(OBUF_W-BYTE_W){1'b0}}};
            ocnt_d = OCNT_W'(1);
            end_d  = 1'b1;
            pend_d = '0;
            cnt_d  = '0;
          end
        end
        default: begin
          ocnt_d = '0;
        end
      endcase
    end else if (out_beat) begin
      obuf_d = obuf_q << BYTE_W;
      ocnt_d = ocnt_q - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      ocnt_q <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
    end_q  <= end_d;
  end

  assign out_o.valid       = (ocnt_q != '0);
  assign out_o.out_byte    = obuf_q[OBUF_W-1:OBUF_W-BYTE_W];
  assign out_o.last_of_run = (ocnt_q == OCNT_W'(1));
  assign out_o.stream_end  = end_q;

  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OCNT_W'(OBUF_BYTES))
    else $error("output byte count above buffer depth");

  a_flush_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stream_end) |-> (ocnt_q == OCNT_W'(1)))
    else $error("flush beat is not a single last beat");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && look_i.kind == KIND_FLUSH) |=> (cnt_q == '0 && pend_q == '0))
    else $error("flush left pending bits");

  a_drain_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q > OCNT_W'(1)) |=> (ocnt_q != '0 && !$fell(out_o.valid)))
    else $error("multi-byte run ended early");

endmodule
